// File: rtl/ssgt_pkg.sv
// Shared constants and types for the shell sort block with a programmable gap table.
package ssgt_pkg;

    localparam int MaxKeys  = 64;
    localparam int KeyW     = 32;
    localparam int CntW     = $clog2(MaxKeys + 1);
    localparam int AddrW    = $clog2(MaxKeys);
    localparam int GapW     = 6;
    localparam int PassW    = 3;
    localparam int NumGaps  = 6;
    localparam int GapIdxW  = $clog2(NumGaps);
    localparam int WideW    = (CntW > GapW) ? CntW : GapW;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 6;

    localparam logic [CfgIdxW-1:0] CfgPassCount = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgGapFirst  = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgGapLast   = 3'd6;

    typedef logic signed [KeyW-1:0] t_key;
    typedef logic [CntW-1:0]        t_cnt;

endpackage

// File: rtl/shell_sort_with_gap_table.sv
// Top level of the shell sort block: key loading, gapped insertion passes and key output.
//
//  Channel   Direction  Ports                                        Handshake
//  request   in         i_key_in, i_last_in                          start && !busy
//  result    out        o_key_out, o_last_out, o_dropped             o_valid, one cycle each
//  config    in         i_cfg_idx, i_cfg_data                        i_cfg_we
//
// Loading accepts one key per cycle while start is high. After the last key the gap slots
// are visited in order up to the pass count, saturated at six; a zero gap or a gap not below
// the key count is skipped, and an active gap inserts each element from the gap upwards,
// shifting larger keys along its chain. Output shows one stored key per cycle. Reset
// clears the key count and dropped flag and sets the pass count and all gaps to 1; the key
// RAM is not cleared. Results cannot be stalled, and start is ignored while busy is high.
module shell_sort_with_gap_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  ssgt_pkg::t_key                    i_key_in,
    input  logic                              i_last_in,
    output logic                              o_valid,
    output ssgt_pkg::t_key                    o_key_out,
    output logic                              o_last_out,
    output logic                              o_dropped,
    input  logic                              i_cfg_we,
    input  logic [ssgt_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [ssgt_pkg::CfgDataW-1:0]     i_cfg_data
);

    import ssgt_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PASS  = 4'd1;
    localparam logic [3:0] ST_IRD   = 4'd2;
    localparam logic [3:0] ST_IHOLD = 4'd3;
    localparam logic [3:0] ST_JRD   = 4'd4;
    localparam logic [3:0] ST_JCMP  = 4'd5;
    localparam logic [3:0] ST_PUT   = 4'd6;
    localparam logic [3:0] ST_EMIT  = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0]       r_state, n_state;
    t_cnt             r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic [PassW-1:0] r_pass_cnt;
    logic [GapW-1:0]  r_gap [NumGaps];
    logic [PassW-1:0] r_p, n_p;
    t_cnt             r_step_gap, n_step_gap;
    t_cnt             r_i, n_i;
    t_cnt             r_j, n_j;
    t_key             r_held, n_held;
    logic             r_out_v, n_out_v;
    logic             r_out_last, n_out_last;

    logic             ram_we;
    logic [AddrW-1:0] ram_waddr;
    t_key             ram_wdata;
    logic [AddrW-1:0] ram_raddr;
    t_key             ram_rdata;

    logic [PassW-1:0] passes_sat;
    logic [GapW-1:0]  cur_gap;
    t_cnt             j_minus;
    logic             j_ge;
    logic             key_lt;
    t_cnt             i_next;

    assign passes_sat = (r_pass_cnt > PassW'(NumGaps)) ? PassW'(NumGaps) : r_pass_cnt;
    assign cur_gap    = r_gap[r_p[GapIdxW-1:0]];
    assign j_minus    = r_j - r_step_gap;
    assign j_ge       = (r_j >= r_step_gap);
    assign key_lt     = (r_held < ram_rdata);
    assign i_next     = r_i + t_cnt'(1);

    ssgt_ram #(
        .Width(KeyW),
        .Depth(MaxKeys)
    ) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ovf      = r_ovf;
        n_p        = r_p;
        n_step_gap = r_step_gap;
        n_i        = r_i;
        n_j        = r_j;
        n_held     = r_held;
        n_out_v    = 1'b0;
        n_out_last = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_cnt[AddrW-1:0];
        ram_wdata  = i_key_in;
        ram_raddr  = r_i[AddrW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (r_cnt < t_cnt'(MaxKeys)) begin
                        ram_we = 1'b1;
                        n_cnt  = r_cnt + t_cnt'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_in) begin
                        n_p     = '0;
                        n_state = ST_PASS;
                    end
                end
            end
            ST_PASS: begin
                if (r_p >= passes_sat) begin
                    n_i     = '0;
                    n_state = ST_EMIT;
                end else if ((cur_gap == '0) ||
                             (WideW'(cur_gap) >= WideW'(r_cnt))) begin
                    n_p = r_p + PassW'(1);
                end else begin
                    n_step_gap = t_cnt'(cur_gap);
                    n_i        = t_cnt'(cur_gap);
                    n_state    = ST_IRD;
                end
            end
            ST_IRD: begin
                ram_raddr = r_i[AddrW-1:0];
                n_state   = ST_IHOLD;
            end
            ST_IHOLD: begin
                n_held  = ram_rdata;
                n_j     = r_i;
                n_state = ST_JRD;
            end
            ST_JRD: begin
                if (j_ge) begin
                    ram_raddr = j_minus[AddrW-1:0];
                    n_state   = ST_JCMP;
                end else begin
                    n_state = ST_PUT;
                end
            end
            ST_JCMP: begin
                if (key_lt) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_j[AddrW-1:0];
                    ram_wdata = ram_rdata;
                    n_j       = j_minus;
                    n_state   = ST_JRD;
                end else begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[AddrW-1:0];
                ram_wdata = r_held;
                if (i_next < r_cnt) begin
                    n_i     = i_next;
                    n_state = ST_IRD;
                end else begin
                    n_p     = r_p + PassW'(1);
                    n_state = ST_PASS;
                end
            end
            ST_EMIT: begin
                ram_raddr  = r_i[AddrW-1:0];
                n_out_v    = 1'b1;
                n_out_last = (i_next == r_cnt);
                if (i_next == r_cnt) begin
                    n_state = ST_DONE;
                end else begin
                    n_i = i_next;
                end
            end
            ST_DONE: begin
                n_cnt   = '0;
                n_ovf   = 1'b0;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_ovf      <= 1'b0;
            r_out_v    <= 1'b0;
            r_out_last <= 1'b0;
            r_pass_cnt <= PassW'(1);
            for (int g = 0; g < NumGaps; g++) begin
                r_gap[g] <= GapW'(1);
            end
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_ovf      <= n_ovf;
            r_out_v    <= n_out_v;
            r_out_last <= n_out_last;
            if (i_cfg_we) begin
                if (i_cfg_idx == CfgPassCount) begin
                    r_pass_cnt <= i_cfg_data[PassW-1:0];
                end else if (i_cfg_idx inside {[CfgGapFirst:CfgGapLast]}) begin
                    r_gap[GapIdxW'(i_cfg_idx - CfgGapFirst)] <= i_cfg_data[GapW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p        <= n_p;
        r_step_gap <= n_step_gap;
        r_i        <= n_i;
        r_j        <= n_j;
        r_held     <= n_held;
    end

    assign busy       = (r_state != ST_IDLE);
    assign o_valid    = r_out_v;
    assign o_key_out  = ram_rdata;
    assign o_last_out = r_out_last;
    assign o_dropped  = r_ovf;

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("A result was shown while the block was idle.");

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_out |-> o_valid)
        else $error("The last marker was raised without a result.");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (o_valid && o_last_out))
        else $error("The set finished without its last result.");

    a_last_request_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_in) |=> busy)
        else $error("The final request of a set did not start the sort.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= t_cnt'(MaxKeys))
        else $error("The key count ran past the capacity of the store.");

endmodule

// File: rtl/ssgt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ssgt_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the shell sort block with a programmable gap table.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ssgt_pkg::*;

    localparam logic [CfgIdxW-1:0] CfgUnmapped = 3'd7;
    localparam int unsigned        SettleCycles = 8;
    localparam int unsigned        ItemTarget   = 430;
    localparam int unsigned        CalmTail     = 60;
    localparam t_key               KeyMax       = 32'sh7FFF_FFFF;
    localparam t_key               KeyMin       = 32'sh8000_0000;

    typedef enum logic [1:0] {
        OP_KEY,
        OP_REG,
        OP_SYNC
    } op_kind_e;

    typedef struct {
        op_kind_e             kind;
        t_key                 key;
        logic                 last;
        logic [CfgIdxW-1:0]   idx;
        logic [CfgDataW-1:0]  data;
        int unsigned          idle;
    } sort_cmd_t;

    typedef struct {
        t_key key;
        logic last;
        logic dropped;
    } sorted_key_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_key                 key_in      = '0;
    logic                 last_in     = 1'b0;
    logic                 res_valid;
    t_key                 res_key;
    logic                 res_last;
    logic                 res_dropped;
    logic                 cfg_we      = 1'b0;
    logic [CfgIdxW-1:0]   cfg_idx     = '0;
    logic [CfgDataW-1:0]  cfg_data    = '0;

    // Pending requests and register writes, in issue order.
    sort_cmd_t            pending_ops[$];
    sorted_key_t          sorted_out[$];

    t_key                 sort_store[MaxKeys];
    int unsigned          stored_n;
    logic                 spill;
    logic [PassW-1:0]     pass_reg;
    logic [GapW-1:0]      gap_tab[NumGaps];

    int unsigned          hold_off;
    bit                   gap_armed;
    int unsigned          quiet_run;
    int unsigned          errors;
    int unsigned          burst_odds;

    shell_sort_with_gap_table dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_key_in   (key_in),
        .i_last_in  (last_in),
        .o_valid    (res_valid),
        .o_key_out  (res_key),
        .o_last_out (res_last),
        .o_dropped  (res_dropped),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void gapped_insert(int g, int n);
        t_key held;
        int   j;
        if (g == 0 || g >= n) return;
        for (int i = g; i < n; i++) begin
            held = sort_store[i];
            j = i;
            while (j >= g && held < sort_store[j - g]) begin
                sort_store[j] = sort_store[j - g];
                j -= g;
            end
            sort_store[j] = held;
        end
    endfunction

    function automatic void take_key(t_key k, logic last);
        int          used;
        sorted_key_t r;
        if (stored_n < MaxKeys) begin
            sort_store[stored_n] = k;
            stored_n++;
        end else begin
            spill = 1'b1;
        end
        if (last) begin
            used = (pass_reg > NumGaps) ? NumGaps : int'(pass_reg);
            for (int p = 0; p < used; p++)
                gapped_insert(int'(gap_tab[p]), int'(stored_n));
            for (int e = 0; e < int'(stored_n); e++) begin
                r.key     = sort_store[e];
                r.last    = (e == int'(stored_n) - 1);
                r.dropped = spill;
                sorted_out.push_back(r);
            end
            stored_n = 0;
            spill    = 1'b0;
        end
    endfunction

    function automatic void apply_reg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        if (idx == CfgPassCount)
            pass_reg = data[PassW-1:0];
        else if (idx >= CfgGapFirst && idx <= CfgGapLast)
            gap_tab[idx - CfgGapFirst] = data[GapW-1:0];
    endfunction

    function automatic int unsigned draw_idle();
        if (burst_odds != 0 && $urandom_range(0, burst_odds - 1) == 0)
            return $urandom_range(1, 19);
        return 0;
    endfunction

    function automatic void push_key(t_key k, logic last);
        sort_cmd_t c;
        c.kind = OP_KEY;
        c.key  = k;
        c.last = last;
        c.idx  = '0;
        c.data = '0;
        c.idle = draw_idle();
        pending_ops.push_back(c);
    endfunction

    function automatic void push_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        sort_cmd_t c;
        c.kind = OP_REG;
        c.key  = '0;
        c.last = 1'b0;
        c.idx  = idx;
        c.data = data;
        c.idle = 0;
        pending_ops.push_back(c);
    endfunction

    function automatic void push_sync();
        sort_cmd_t c;
        c.kind = OP_SYNC;
        c.key  = '0;
        c.last = 1'b0;
        c.idx  = '0;
        c.data = '0;
        c.idle = 0;
        pending_ops.push_back(c);
    endfunction

    function automatic t_key draw_key(int style);
        int unsigned r;
        r = $urandom_range(0, 5);
        case (style)
            0: return t_key'($urandom);
            1: return t_key'($urandom_range(0, 6)) - 3;
            default: begin
                if (r == 0) return KeyMax;
                if (r == 1) return KeyMin;
                if (r == 2) return '0;
                return t_key'($urandom);
            end
        endcase
    endfunction

    always @(posedge clk) begin
        sort_cmd_t head;
        logic      nxt_start;
        logic      nxt_we;
        logic      launch;
        nxt_start = start;
        nxt_we    = 1'b0;
        launch    = 1'b0;
        head      = '{OP_SYNC, '0, 1'b0, '0, '0, 0};
        if (!rst_n) begin
            nxt_start = 1'b0;
            hold_off  = 0;
            gap_armed = 1'b0;
            quiet_run = 0;
            stored_n  = 0;
            spill     = 1'b0;
            pass_reg  = PassW'(1);
            for (int g = 0; g < NumGaps; g++)
                gap_tab[g] = GapW'(1);
        end else begin
            if (start && !busy) begin
                take_key(key_in, last_in);
                nxt_start = 1'b0;
            end
            if (cfg_we)
                apply_reg_write(cfg_idx, cfg_data);
            if (sorted_out.size() == 0 && !busy && !start)
                quiet_run++;
            else
                quiet_run = 0;
            if (!nxt_start && !cfg_we && pending_ops.size() > 0) begin
                head = pending_ops[0];
                if (!gap_armed) begin
                    hold_off  = head.idle;
                    gap_armed = 1'b1;
                end
                if (hold_off > 0) begin
                    hold_off--;
                end else begin
                    case (head.kind)
                        OP_KEY: begin
                            nxt_start = 1'b1;
                            launch    = 1'b1;
                            void'(pending_ops.pop_front());
                            gap_armed = 1'b0;
                        end
                        OP_REG: if (quiet_run >= SettleCycles) begin
                            nxt_we = 1'b1;
                            void'(pending_ops.pop_front());
                            gap_armed = 1'b0;
                        end
                        default: if (quiet_run >= SettleCycles) begin
                            void'(pending_ops.pop_front());
                            gap_armed = 1'b0;
                        end
                    endcase
                end
            end
        end
        start  <= nxt_start;
        cfg_we <= nxt_we;
        if (launch) begin
            key_in  <= head.key;
            last_in <= head.last;
        end
        if (nxt_we) begin
            cfg_idx  <= head.idx;
            cfg_data <= head.data;
        end
    end

    always @(posedge clk) begin
        sorted_key_t want;
        if (rst_n && res_valid) begin
            if (sorted_out.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: key %0d last %0b dropped %0b",
                             res_key, res_last, res_dropped);
            end else begin
                want = sorted_out.pop_front();
                if (res_key !== want.key || res_last !== want.last
                        || res_dropped !== want.dropped) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected key %0d last %0b dropped %0b, got key %0d last %0b dropped %0b",
                                 want.key, want.last, want.dropped,
                                 res_key, res_last, res_dropped);
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("shell_sort_with_gap_table verification failed");
        $finish;
    end

    initial begin
        int unsigned made;
        int unsigned set_no;
        int unsigned size;
        int unsigned r;
        int          style;
        int unsigned pc;
        int unsigned top_pass;
        logic [GapW-1:0] gaps[NumGaps];

        errors     = 0;
        burst_odds = 4;

        // Full ascending sort with the reset table, extremes and equal keys.
        push_key(KeyMax, 1'b0);
        push_key(KeyMin, 1'b0);
        push_key(0, 1'b0);
        push_key(-1, 1'b0);
        push_key(5, 1'b0);
        push_key(-7, 1'b0);
        push_key(5, 1'b0);
        push_key(KeyMin, 1'b1);

        // Saturated pass count, zero gaps and a gap beyond the set size.
        push_reg(CfgPassCount, 6'b101111);
        push_reg(CfgGapFirst,     6'd0);
        push_reg(CfgIdxW'(CfgGapFirst + 1), 6'd63);
        push_reg(CfgIdxW'(CfgGapFirst + 2), 6'd3);
        push_reg(CfgIdxW'(CfgGapFirst + 3), 6'd2);
        push_reg(CfgIdxW'(CfgGapFirst + 4), 6'd1);
        push_reg(CfgGapLast,      6'd0);
        push_reg(CfgUnmapped,     6'h3F);
        push_key(3, 1'b0);
        push_key(-2, 1'b0);
        push_key(3, 1'b0);
        push_key(100, 1'b0);
        push_key(-100, 1'b0);
        push_key(0, 1'b0);
        push_key(3, 1'b0);
        push_key(KeyMin, 1'b0);
        push_key(KeyMax, 1'b1);

        // A set of one key.
        push_key(-1, 1'b1);

        // No passes at all: store order comes out unchanged.
        push_reg(CfgPassCount, 6'd0);
        push_key(9, 1'b0);
        push_key(-9, 1'b0);
        push_key(4, 1'b1);

        made   = 21;
        set_no = 0;
        while (made < ItemTarget) begin
            r = $urandom_range(0, 2);
            burst_odds = (made >= ItemTarget - CalmTail) ? 0 : (r == 0) ? 0 : (r == 1) ? 3 : 8;
            r = $urandom_range(0, 5);
            if (set_no == 0 || r < 3) begin
                pc = $urandom_range(0, 7);
                for (int g = 0; g < NumGaps; g++) begin
                    r = $urandom_range(0, 9);
                    gaps[g] = (r == 0) ? 6'd0 : (r == 1) ? 6'd63 :
                              (r < 7) ? GapW'($urandom_range(1, 5)) :
                              GapW'($urandom_range(1, 63));
                end
                top_pass = (pc > NumGaps) ? NumGaps : pc;
                if (top_pass != 0 && $urandom_range(0, 2) != 0)
                    gaps[top_pass - 1] = 6'd1;
                push_reg(CfgPassCount, {3'($urandom_range(0, 7)), 3'(pc)});
                for (int g = 0; g < NumGaps; g++)
                    push_reg(CfgIdxW'(CfgGapFirst + g), gaps[g]);
                if ($urandom_range(0, 4) == 0)
                    push_reg(CfgUnmapped, CfgDataW'($urandom));
            end else if (r == 3) begin
                push_sync();
            end
            r = $urandom_range(0, 9);
            if (set_no == 1 || set_no == 9 || r == 0)
                size = $urandom_range(MaxKeys, MaxKeys + 3);
            else if (r < 3)
                size = $urandom_range(17, 40);
            else
                size = $urandom_range(1, 16);
            style = $urandom_range(0, 2);
            for (int k = 0; k < int'(size); k++)
                push_key(draw_key(style), k == int'(size) - 1);
            made += size;
            set_no++;
        end
        push_sync();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || start || cfg_we)
            @(posedge clk);
        while (sorted_out.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (sorted_out.size() != 0) begin
            errors++;
            $display("%0d expected results never arrived", sorted_out.size());
        end
        if (errors == 0)
            $display("shell_sort_with_gap_table verification clean");
        else
            $display("shell_sort_with_gap_table verification failed");
        $finish;
    end

endmodule

// File: shell_sort_with_gap_table.f
rtl/ssgt_pkg.sv
rtl/ssgt_ram.sv
rtl/shell_sort_with_gap_table.sv
tb/sv/tb_top.sv
